/* src/pfba_pkg.sv */
// Shared types and constants for the page frame bitmap allocator.
package pfba_pkg;

  localparam int unsigned FRAME_BITS          = 14;
  localparam int unsigned FRAME_FIELD_LIMIT   = 16384;
  localparam int unsigned DEFAULT_FRAME_COUNT = 16384;
  localparam int unsigned DEFAULT_WORD_BITS   = 64;

  // Words of the bitmap grouped per row of the two-level free search.
  localparam int unsigned CHUNK_WORDS = 32;

  // Reciprocal used to split a frame number into word and bit index.
  localparam int unsigned RECIP_SHIFT = 21;
  localparam int unsigned RECIP_W     = 19;

  typedef enum logic [1:0] {
    OP_ALLOC     = 2'd0,
    OP_MARK_USED = 2'd1,
    OP_MARK_FREE = 2'd2,
    OP_QUERY     = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [FRAME_BITS-1:0] frame_number;
  } req_t;

  typedef struct packed {
    logic [FRAME_BITS-1:0] result_frame;
    logic                  status;
    logic                  frame_used;
  } rsp_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic divide;
    logic locate;
    logic rd;
    logic modify;
    logic scale;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } stat_t;

endpackage

/* src/pfba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pfba_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/pfba_ctrl.sv */
// Sequencer for the allocator: clearing pass, per-item steps and the output handshake.
module pfba_ctrl import pfba_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIVIDE,
    S_LOCATE,
    S_READ,
    S_MODIFY,
    S_SCALE,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        cmd_o.divide = 1'b1;
        state_d      = S_LOCATE;
      end
      S_LOCATE: begin
        cmd_o.locate = 1'b1;
        state_d      = S_READ;
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_MODIFY;
      end
      S_MODIFY: begin
        cmd_o.modify = 1'b1;
        state_d      = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_OUT;
      end
      S_OUT: begin
        // The result waits here until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* src/pfba_dp.sv */
// Datapath of the allocator: bitmap memory, full-word summary, search and result registers.
module pfba_dp import pfba_pkg::*; #(
  parameter int unsigned FRAME_COUNT = DEFAULT_FRAME_COUNT,
  parameter int unsigned WORD_BITS   = DEFAULT_WORD_BITS
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cmd_t  cmd_i,
  output stat_t stat_o,
  input  req_t  req_i,
  output rsp_t  rsp_o
);

  // Only frames that exist and that a 14-bit frame number can name are kept.
  localparam int unsigned SCAN_LIMIT = (FRAME_COUNT < FRAME_FIELD_LIMIT) ?
                                       FRAME_COUNT : FRAME_FIELD_LIMIT;
  localparam int unsigned SCAN_WORDS = (SCAN_LIMIT + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW         = (SCAN_WORDS > 1) ? $clog2(SCAN_WORDS) : 1;
  localparam int unsigned BW         = $clog2(WORD_BITS);
  localparam int unsigned NCHUNK     = (SCAN_WORDS + CHUNK_WORDS - 1) / CHUNK_WORDS;
  localparam int unsigned CW         = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int unsigned CIW        = $clog2(CHUNK_WORDS);
  localparam int unsigned PW         = FRAME_BITS + RECIP_W;
  localparam int unsigned QW         = PW - RECIP_SHIFT;
  localparam int unsigned FW1        = FRAME_BITS + 1;
  localparam int unsigned LAST_BITS  = SCAN_LIMIT - (SCAN_WORDS - 1) * WORD_BITS;

  localparam logic [RECIP_W-1:0]    RECIP    = RECIP_W'((2 ** RECIP_SHIFT + WORD_BITS - 1) /
                                                        WORD_BITS);
  localparam logic [FRAME_BITS-1:0] WB_C     = FRAME_BITS'(WORD_BITS);
  localparam logic [FW1-1:0]        LIMIT_C  = FW1'(SCAN_LIMIT);
  localparam logic [AW-1:0]         LAST_W   = AW'(SCAN_WORDS - 1);
  localparam logic [WORD_BITS-1:0]  LAST_MSK = {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);

  // Item registers.
  opcode_e               op_q;
  logic [FRAME_BITS-1:0] f_q;
  logic [QW-1:0]         q_q;
  logic [BW-1:0]         b_q;
  logic                  exists_q;
  logic [CW-1:0]         chunk_q;
  logic                  found_q;
  logic [AW-1:0]         addr_q;
  logic                  used_q;
  logic [BW-1:0]         bit_q;
  logic                  status_q;
  logic [FRAME_BITS-1:0] frame_q;
  rsp_t                  out_q;

  // Control state: one full flag per word and the clearing counter.
  logic [SCAN_WORDS-1:0] full_q;
  logic [AW-1:0]         clr_q;

  logic                                   is_alloc;
  logic [PW-1:0]                          prod;
  logic [FRAME_BITS-1:0]                  qwb;
  logic [FRAME_BITS-1:0]                  rem;
  logic [NCHUNK*CHUNK_WORDS-1:0]          full_pad;
  logic [NCHUNK-1:0][CHUNK_WORDS-1:0]     full_rows;
  logic [NCHUNK-1:0]                      chunk_free;
  logic [CW-1:0]                          chunk_sel;
  logic [CHUNK_WORDS-1:0]                 row_free;
  logic [CIW-1:0]                         inner_sel;
  logic [WORD_BITS-1:0]                   rdata;
  logic [WORD_BITS-1:0]                   word_mask;
  logic [WORD_BITS-1:0]                   free_bits;
  logic [BW-1:0]                          free_bit;
  logic [WORD_BITS-1:0]                   new_word;
  logic                                   wr_ok;
  logic                                   ram_we;
  logic [AW-1:0]                          ram_waddr;
  logic [WORD_BITS-1:0]                   ram_wdata;
  logic [FRAME_BITS-1:0]                  scaled;

  assign is_alloc = (op_q == OP_ALLOC);

  // Word index by multiplying with the reciprocal; exact for 14-bit frame numbers.
  assign prod = PW'(f_q) * PW'(RECIP);
  assign qwb  = FRAME_BITS'(FRAME_BITS'(q_q) * WB_C);
  assign rem  = f_q - qwb;

  // Two-level search for the lowest word that still has a free frame.
  always_comb begin
    full_pad                   = '1;
    full_pad[SCAN_WORDS-1:0]   = full_q;
  end
  assign full_rows = full_pad;

  always_comb begin
    for (int c = 0; c < NCHUNK; c++) begin
      chunk_free[c] = ~&full_rows[c];
    end
  end

  always_comb begin
    chunk_sel = '0;
    for (int c = NCHUNK - 1; c >= 0; c--) begin
      if (chunk_free[c]) begin
        chunk_sel = CW'(c);
      end
    end
  end

  assign row_free = ~full_rows[chunk_q];

  always_comb begin
    inner_sel = '0;
    for (int i = CHUNK_WORDS - 1; i >= 0; i--) begin
      if (row_free[i]) begin
        inner_sel = CIW'(i);
      end
    end
  end

  // Read-modify-write of one bitmap word.
  assign word_mask = (addr_q == LAST_W) ? LAST_MSK : '1;
  assign free_bits = ~rdata & word_mask;

  always_comb begin
    free_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        free_bit = BW'(i);
      end
    end
  end

  always_comb begin
    new_word = rdata;
    wr_ok    = 1'b0;
    case (op_q)
      OP_ALLOC: begin
        new_word = rdata | (WORD_BITS'(1) << free_bit);
        wr_ok    = found_q;
      end
      OP_MARK_USED: begin
        new_word = rdata | (WORD_BITS'(1) << b_q);
        wr_ok    = exists_q;
      end
      OP_MARK_FREE: begin
        new_word = rdata & ~(WORD_BITS'(1) << b_q);
        wr_ok    = exists_q;
      end
      default: begin
        new_word = rdata;
        wr_ok    = 1'b0;
      end
    endcase
  end

  assign ram_we    = cmd_i.clr_step | (cmd_i.modify & wr_ok);
  assign ram_waddr = cmd_i.clr_step ? clr_q : addr_q;
  assign ram_wdata = cmd_i.clr_step ? '0 : new_word;

  pfba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (SCAN_WORDS)
  ) u_bitmap_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  assign scaled = FRAME_BITS'(FRAME_BITS'(addr_q) * WB_C) + FRAME_BITS'(bit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= '0;
      clr_q  <= '0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.modify && wr_ok) begin
        full_q[addr_q] <= &(new_word | ~word_mask);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= opcode_e'(req_i.opcode);
      f_q  <= req_i.frame_number;
    end
    if (cmd_i.divide) begin
      q_q      <= prod[PW-1:RECIP_SHIFT];
      chunk_q  <= chunk_sel;
      found_q  <= |chunk_free;
      exists_q <= ({1'b0, f_q} < LIMIT_C);
    end
    if (cmd_i.locate) begin
      b_q    <= rem[BW-1:0];
      addr_q <= is_alloc ? AW'({chunk_q, inner_sel}) : AW'(q_q);
    end
    if (cmd_i.modify) begin
      bit_q  <= free_bit;
      used_q <= !is_alloc && exists_q && rdata[b_q];
    end
    if (cmd_i.scale) begin
      status_q <= is_alloc && !found_q;
      if (is_alloc) begin
        frame_q <= found_q ? scaled : '0;
      end else begin
        frame_q <= f_q;
      end
    end
    if (cmd_i.out_load) begin
      out_q.result_frame <= frame_q;
      out_q.status       <= status_q;
      out_q.frame_used   <= used_q;
    end
  end

  assign stat_o.clr_last = (clr_q == LAST_W);
  assign rsp_o           = out_q;

endmodule

/* src/page_frame_bitmap_allocator.sv */
// Top level of the page frame bitmap allocator: sequencer, datapath and checks.
//
// Requests enter on the in channel (valid/ready) as an opcode and a frame number:
// allocate the lowest free frame, mark a frame used, mark it free, or query it.
// Every request gives exactly one result on the out channel (valid/ready): the
// frame (allocated or echoed), a no-free-frame status and the frame's old used bit.
// The bitmap sits in a RAM of one word per WORD_BITS frames; a flip-flop per word
// records that the word is full, so allocate finds its word by a two-level search
// over those flags (rows of 32 words) instead of scanning the memory.
// An accepted request runs through the step sequence of divide, search, memory
// read, read-modify-write, frame scaling and output load, and out_valid_o rises
// once its output load is done; a new request is accepted only when the block is
// back in idle after that output load, so requests are not overlapped.
// After reset the block clears the bitmap one word per cycle, over all of its
// ceil(min(FRAME_COUNT, 16384) / WORD_BITS) words (256 at the defaults), with
// in_ready_o low; afterwards every frame is free.
// The result sits in an output register. While the receiver stalls, the next
// request is still accepted and worked on, and waits in its last step until the
// output register is taken.
module page_frame_bitmap_allocator import pfba_pkg::*; #(
  parameter int unsigned FRAME_COUNT = DEFAULT_FRAME_COUNT,
  parameter int unsigned WORD_BITS   = DEFAULT_WORD_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  cmd_t  cmd;
  stat_t stat;

  pfba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pfba_dp #(
    .FRAME_COUNT (FRAME_COUNT),
    .WORD_BITS   (WORD_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat),
    .req_i  (in_data_i),
    .rsp_o  (out_data_o)
  );

  // No item is taken while the bitmap is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_step |-> !in_ready_o)
    else $error("item accepted during the clearing pass");

  // An accepted item has a result waiting in the output register after its step sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> ##7 out_valid_o)
    else $error("result missing after an accepted item");

  // A failed allocate reports frame zero and a clear used bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status) |->
      (!out_data_o.frame_used && (out_data_o.result_frame == '0)))
    else $error("failed allocate carries a frame or used bit");

  // The memory is written only by the clearing pass or the modify step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.clr_step || cmd.modify) |-> !in_ready_o)
    else $error("bitmap written while the block is idle");

endmodule
